FILE: hdl/pbr_pkg.sv
// Package with the shared types, constants and helpers of the bandwidth reservation block.
package pbr_pkg;

  localparam int NODE_W   = 6;
  localparam int EDGE_W   = 2 * NODE_W;
  localparam int RATE_W   = 48;
  localparam int FLOW_W   = 8;
  localparam int HOP_W    = 4;
  localparam int HIDX_W   = 3;
  localparam int MAX_HOPS = 8;
  localparam int CNT_W    = 9;
  localparam int SWEEP_W  = EDGE_W + 1;

  typedef enum logic [2:0] {
    CMD_CLEAR   = 3'd0,
    CMD_ADD     = 3'd1,
    CMD_PATH    = 3'd2,
    CMD_RELEASE = 3'd3,
    CMD_QUERY   = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_ZERO_RATE = 3'd2,
    ST_INACTIVE  = 3'd3,
    ST_NO_ROOM   = 3'd4,
    ST_NO_RES    = 3'd5
  } stat_e;

  typedef enum logic [4:0] {
    S_SWEEP,
    S_IDLE,
    S_EXEC,
    S_QRY,
    S_CLR,
    S_PCHK,
    S_CRD,
    S_CEV,
    S_DHDR,
    S_DHEV,
    S_DNRD,
    S_DNEV,
    S_DLEV,
    S_ARD,
    S_AEV,
    S_NW,
    S_RESP
  } state_e;

  function automatic logic [EDGE_W-1:0] edge_idx(input logic [NODE_W-1:0] a,
                                                 input logic [NODE_W-1:0] b);
    logic [NODE_W-1:0] lo;
    logic [NODE_W-1:0] hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    return {lo, hi};
  endfunction

endpackage

FILE: hdl/path_bandwidth_reservation.sv
// Top level of the per-link bandwidth admission control block.
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid_i/in_stall_o   | command, flow, nodes, rate, last
//   out     | output    | out_valid_o/out_stall_i | accepted, status, edge, load, count
//   cfg     | input     | APB psel/penable/pready | link_capacity at byte address 0
//
// A beat is taken only in the idle state; a sequencer then handles each edge with a read state
// followed by an evaluate state. A reservation checks every edge of the path, releases an older
// reservation of the flow if there is one, then adds its rate to each edge and stores its nodes.
// After reset a sweep clears the edge memories before the first input beat.
// A result waits in the output register; the next beat can be taken while it stalls.
module path_bandwidth_reservation (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [2:0]                  in_command_i,
  input  logic [pbr_pkg::FLOW_W-1:0]  in_flow_id_i,
  input  logic [pbr_pkg::NODE_W-1:0]  in_node_a_i,
  input  logic [pbr_pkg::NODE_W-1:0]  in_node_b_i,
  input  logic [pbr_pkg::RATE_W-1:0]  in_rate_i,
  input  logic                        in_last_node_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        out_accepted_o,
  output logic [2:0]                  out_status_o,
  output logic                        out_edge_active_o,
  output logic [pbr_pkg::RATE_W-1:0]  out_edge_load_o,
  output logic [pbr_pkg::CNT_W-1:0]   out_flow_count_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [3:0]                  paddr,
  input  logic [63:0]                 pwdata,
  output logic [63:0]                 prdata,
  output logic                        pready
);

  localparam int RW = pbr_pkg::RATE_W;
  localparam int NW = pbr_pkg::NODE_W;
  localparam int EW = pbr_pkg::EDGE_W;
  localparam int FW = pbr_pkg::FLOW_W;
  localparam int HW = pbr_pkg::HOP_W;
  localparam int IW = pbr_pkg::HIDX_W;
  localparam int CW = pbr_pkg::CNT_W;
  localparam int SW = pbr_pkg::SWEEP_W;

  pbr_pkg::state_e state_q, state_d;

  logic [2:0]    cmd_q, cmd_d;
  logic [FW-1:0] flow_q, flow_d;
  logic [NW-1:0] na_q, na_d, nb_q, nb_d;
  logic [RW-1:0] rate_q, rate_d;
  logic          last_q, last_d;
  logic [RW-1:0] cap_q;

  logic [NW-1:0] pend_q [pbr_pkg::MAX_HOPS];
  logic [NW-1:0] pend_d [pbr_pkg::MAX_HOPS];
  logic [HW-1:0] plen_q, plen_d;
  logic          povf_q, povf_d;
  logic [CW-1:0] held_q, held_d;
  logic [(1<<FW)-1:0] fvalid_q, fvalid_d;

  logic [HW-1:0] idx_q, idx_d;
  logic [NW-1:0] prev_q, prev_d;
  logic [HW-1:0] ohops_q, ohops_d;
  logic [RW-1:0] orate_q, orate_d;
  logic          rsv_q, rsv_d;
  logic [SW-1:0] sweep_q, sweep_d;
  logic [EW-1:0] edge_q;

  logic          racc_q, racc_d;
  logic [2:0]    rst_q, rst_d;
  logic          ract_q, ract_d;
  logic [RW-1:0] rload_q, rload_d;

  logic          ovld_q, ovld_d;
  logic          oacc_q;
  logic [2:0]    ost_q;
  logic          oact_q;
  logic [RW-1:0] oload_q;
  logic [CW-1:0] ocnt_q;

  logic          act_mem  [1<<EW];
  logic [RW-1:0] load_mem [1<<EW];
  logic [RW-1:0] frate_mem [1<<FW];
  logic [HW-1:0] fhops_mem [1<<FW];
  logic [NW-1:0] fnode_mem [(1<<FW)*pbr_pkg::MAX_HOPS];

  logic          act_rd_q;
  logic [RW-1:0] load_rd_q;
  logic [RW-1:0] frate_rd_q;
  logic [HW-1:0] fhops_rd_q;
  logic [NW-1:0] fnode_rd_q;

  logic          act_we, load_we, fnode_we, fflow_we;
  logic [EW-1:0] e_ra, act_wa, load_wa;
  logic          act_wd;
  logic [RW-1:0] load_wd;
  logic [NW-1:0] fnode_wd;

  logic          in_acc, out_acc, cfg_wr;
  logic [NW-1:0] pend_cur;
  logic          idx_last, dn_last, room_fail;
  logic [RW:0]   sum_w;
  logic [RW-1:0] sat_add, sat_sub;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_acc  = ovld_q && !out_stall_i;
  assign cfg_wr   = psel && penable && pwrite && pready && !paddr[3];
  assign pready   = 1'b1;
  assign prdata   = paddr[3] ? 64'd0 : {{(64-RW){1'b0}}, cap_q};
  assign in_stall_o = (state_q != pbr_pkg::S_IDLE);

  assign pend_cur  = pend_q[idx_q[IW-1:0]];
  assign idx_last  = (idx_q + HW'(1)) >= plen_q;
  assign dn_last   = (idx_q + HW'(1)) >= ohops_q;
  assign room_fail = (load_rd_q > cap_q) || (rate_q > (cap_q - load_rd_q));
  assign sum_w     = {1'b0, load_rd_q} + {1'b0, rate_q};
  assign sat_add   = sum_w[RW] ? {RW{1'b1}} : sum_w[RW-1:0];
  assign sat_sub   = (load_rd_q > orate_q) ? (load_rd_q - orate_q) : '0;

  always_ff @(posedge clk_i) begin
    if (act_we) begin
      act_mem[act_wa] <= act_wd;
    end
    act_rd_q <= act_mem[e_ra];
  end

  always_ff @(posedge clk_i) begin
    if (load_we) begin
      load_mem[load_wa] <= load_wd;
    end
    load_rd_q <= load_mem[e_ra];
  end

  always_ff @(posedge clk_i) begin
    if (fflow_we) begin
      frate_mem[flow_q] <= rate_q;
      fhops_mem[flow_q] <= plen_q;
    end
    frate_rd_q <= frate_mem[flow_q];
    fhops_rd_q <= fhops_mem[flow_q];
  end

  always_ff @(posedge clk_i) begin
    if (fnode_we) begin
      fnode_mem[{flow_q, idx_q[IW-1:0]}] <= fnode_wd;
    end
    fnode_rd_q <= fnode_mem[{flow_q, idx_q[IW-1:0]}];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pbr_pkg::S_SWEEP: if (sweep_q[EW-1:0] == {EW{1'b1}}) state_d = pbr_pkg::S_IDLE;
      pbr_pkg::S_IDLE:  if (in_acc) state_d = pbr_pkg::S_EXEC;
      pbr_pkg::S_EXEC: begin
        priority case (cmd_q)
          pbr_pkg::CMD_CLEAR:   state_d = pbr_pkg::S_CLR;
          pbr_pkg::CMD_ADD:     state_d = pbr_pkg::S_RESP;
          pbr_pkg::CMD_QUERY:   state_d = pbr_pkg::S_QRY;
          pbr_pkg::CMD_PATH:    state_d = last_q ? pbr_pkg::S_PCHK : pbr_pkg::S_IDLE;
          pbr_pkg::CMD_RELEASE: state_d = fvalid_q[flow_q] ? pbr_pkg::S_DHDR : pbr_pkg::S_RESP;
          default:              state_d = pbr_pkg::S_IDLE;
        endcase
      end
      pbr_pkg::S_QRY: state_d = pbr_pkg::S_RESP;
      pbr_pkg::S_CLR: if (sweep_q[EW-1:0] == {EW{1'b1}}) state_d = pbr_pkg::S_RESP;
      pbr_pkg::S_PCHK: begin
        if (povf_q || plen_q < HW'(2) || rate_q == '0) state_d = pbr_pkg::S_RESP;
        else state_d = pbr_pkg::S_CRD;
      end
      pbr_pkg::S_CRD: state_d = pbr_pkg::S_CEV;
      pbr_pkg::S_CEV: begin
        if (!act_rd_q || room_fail) state_d = pbr_pkg::S_RESP;
        else if (!idx_last) state_d = pbr_pkg::S_CRD;
        else if (fvalid_q[flow_q]) state_d = pbr_pkg::S_DHDR;
        else state_d = pbr_pkg::S_ARD;
      end
      pbr_pkg::S_DHDR: state_d = pbr_pkg::S_DHEV;
      pbr_pkg::S_DHEV: state_d = pbr_pkg::S_DNRD;
      pbr_pkg::S_DNRD: state_d = pbr_pkg::S_DNEV;
      pbr_pkg::S_DNEV: begin
        if (idx_q != '0) state_d = pbr_pkg::S_DLEV;
        else if (dn_last) state_d = rsv_q ? pbr_pkg::S_ARD : pbr_pkg::S_RESP;
        else state_d = pbr_pkg::S_DNRD;
      end
      pbr_pkg::S_DLEV: begin
        if (!dn_last) state_d = pbr_pkg::S_DNRD;
        else state_d = rsv_q ? pbr_pkg::S_ARD : pbr_pkg::S_RESP;
      end
      pbr_pkg::S_ARD: state_d = pbr_pkg::S_AEV;
      pbr_pkg::S_AEV: if (idx_last) state_d = pbr_pkg::S_NW; else state_d = pbr_pkg::S_ARD;
      pbr_pkg::S_NW:  if (idx_last) state_d = pbr_pkg::S_RESP;
      pbr_pkg::S_RESP: if (!ovld_q || !out_stall_i) state_d = pbr_pkg::S_IDLE;
      default: state_d = pbr_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_d    = cmd_q;
    flow_d   = flow_q;
    na_d     = na_q;
    nb_d     = nb_q;
    rate_d   = rate_q;
    last_d   = last_q;
    pend_d   = pend_q;
    plen_d   = plen_q;
    povf_d   = povf_q;
    held_d   = held_q;
    fvalid_d = fvalid_q;
    idx_d    = idx_q;
    prev_d   = prev_q;
    ohops_d  = ohops_q;
    orate_d  = orate_q;
    rsv_d    = rsv_q;
    sweep_d  = sweep_q;
    racc_d   = racc_q;
    rst_d    = rst_q;
    ract_d   = ract_q;
    rload_d  = rload_q;
    ovld_d   = out_acc ? 1'b0 : ovld_q;
    act_we   = 1'b0;
    act_wa   = edge_q;
    act_wd   = 1'b0;
    load_we  = 1'b0;
    load_wa  = edge_q;
    load_wd  = sat_add;
    e_ra     = pbr_pkg::edge_idx(na_q, nb_q);
    fnode_we = 1'b0;
    fnode_wd = pend_cur;
    fflow_we = 1'b0;
    unique case (state_q)
      pbr_pkg::S_SWEEP: begin
        act_we  = 1'b1;
        act_wa  = sweep_q[EW-1:0];
        load_we = 1'b1;
        load_wa = sweep_q[EW-1:0];
        load_wd = '0;
        sweep_d = sweep_q + SW'(1);
      end
      pbr_pkg::S_IDLE: begin
        if (in_acc) begin
          cmd_d  = in_command_i;
          flow_d = in_flow_id_i;
          na_d   = in_node_a_i;
          nb_d   = in_node_b_i;
          rate_d = in_rate_i;
          last_d = in_last_node_i;
        end
      end
      pbr_pkg::S_EXEC: begin
        racc_d  = 1'b0;
        rst_d   = pbr_pkg::ST_OK;
        ract_d  = 1'b0;
        rload_d = '0;
        sweep_d = '0;
        rsv_d   = 1'b0;
        idx_d   = '0;
        priority case (cmd_q)
          pbr_pkg::CMD_CLEAR: racc_d = 1'b1;
          pbr_pkg::CMD_ADD: begin
            act_we = 1'b1;
            act_wa = pbr_pkg::edge_idx(na_q, nb_q);
            act_wd = 1'b1;
            racc_d = 1'b1;
          end
          pbr_pkg::CMD_QUERY: racc_d = 1'b1;
          pbr_pkg::CMD_PATH: begin
            if (plen_q < HW'(pbr_pkg::MAX_HOPS)) begin
              pend_d[plen_q[IW-1:0]] = na_q;
              plen_d = plen_q + HW'(1);
            end else begin
              povf_d = 1'b1;
            end
          end
          pbr_pkg::CMD_RELEASE: if (!fvalid_q[flow_q]) rst_d = pbr_pkg::ST_NO_RES;
          default: ;
        endcase
      end
      pbr_pkg::S_QRY: begin
        ract_d  = act_rd_q && (na_q != nb_q);
        rload_d = load_rd_q;
      end
      pbr_pkg::S_CLR: begin
        act_we  = 1'b1;
        act_wa  = sweep_q[EW-1:0];
        sweep_d = sweep_q + SW'(1);
      end
      pbr_pkg::S_PCHK: begin
        rsv_d  = 1'b1;
        idx_d  = HW'(1);
        prev_d = pend_q[0];
        if (povf_q || plen_q < HW'(2)) rst_d = pbr_pkg::ST_INVALID;
        else if (rate_q == '0) rst_d = pbr_pkg::ST_ZERO_RATE;
        if (povf_q || plen_q < HW'(2) || rate_q == '0) begin
          plen_d = '0;
          povf_d = 1'b0;
        end
      end
      pbr_pkg::S_CRD: e_ra = pbr_pkg::edge_idx(prev_q, pend_cur);
      pbr_pkg::S_CEV: begin
        prev_d = pend_cur;
        idx_d  = idx_q + HW'(1);
        if (!act_rd_q || room_fail) begin
          rst_d  = !act_rd_q ? pbr_pkg::ST_INACTIVE : pbr_pkg::ST_NO_ROOM;
          plen_d = '0;
          povf_d = 1'b0;
        end else if (idx_last) begin
          idx_d  = fvalid_q[flow_q] ? '0 : HW'(1);
          prev_d = pend_q[0];
        end
      end
      pbr_pkg::S_DHDR: ;
      pbr_pkg::S_DHEV: begin
        orate_d = frate_rd_q;
        ohops_d = fhops_rd_q;
        idx_d   = '0;
      end
      pbr_pkg::S_DNRD: ;
      pbr_pkg::S_DNEV: begin
        prev_d = fnode_rd_q;
        e_ra   = pbr_pkg::edge_idx(prev_q, fnode_rd_q);
        if (idx_q == '0) begin
          idx_d = HW'(1);
          if (dn_last) begin
            fvalid_d[flow_q] = 1'b0;
            held_d = (held_q != '0) ? held_q - CW'(1) : held_q;
            racc_d = 1'b1;
            idx_d  = HW'(1);
            prev_d = pend_q[0];
          end
        end
      end
      pbr_pkg::S_DLEV: begin
        load_we = 1'b1;
        load_wd = sat_sub;
        idx_d   = idx_q + HW'(1);
        if (dn_last) begin
          fvalid_d[flow_q] = 1'b0;
          held_d = (held_q != '0) ? held_q - CW'(1) : held_q;
          racc_d = 1'b1;
          idx_d  = HW'(1);
          prev_d = pend_q[0];
        end
      end
      pbr_pkg::S_ARD: e_ra = pbr_pkg::edge_idx(prev_q, pend_cur);
      pbr_pkg::S_AEV: begin
        load_we = 1'b1;
        load_wd = sat_add;
        prev_d  = pend_cur;
        idx_d   = idx_last ? '0 : idx_q + HW'(1);
      end
      pbr_pkg::S_NW: begin
        fnode_we = 1'b1;
        idx_d    = idx_q + HW'(1);
        if (idx_last) begin
          fflow_we = 1'b1;
          fvalid_d[flow_q] = 1'b1;
          held_d = held_q + CW'(1);
          racc_d = 1'b1;
          rst_d  = pbr_pkg::ST_OK;
          plen_d = '0;
          povf_d = 1'b0;
        end
      end
      pbr_pkg::S_RESP: if (!ovld_q || !out_stall_i) ovld_d = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= pbr_pkg::S_SWEEP;
      sweep_q  <= '0;
      plen_q   <= '0;
      povf_q   <= 1'b0;
      held_q   <= '0;
      fvalid_q <= '0;
      ovld_q   <= 1'b0;
      cap_q    <= RW'(64'd100000000000);
      idx_q    <= '0;
      rsv_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      sweep_q  <= sweep_d;
      plen_q   <= plen_d;
      povf_q   <= povf_d;
      held_q   <= held_d;
      fvalid_q <= fvalid_d;
      ovld_q   <= ovld_d;
      idx_q    <= idx_d;
      rsv_q    <= rsv_d;
      if (cfg_wr) begin
        cap_q <= pwdata[RW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    flow_q  <= flow_d;
    na_q    <= na_d;
    nb_q    <= nb_d;
    rate_q  <= rate_d;
    last_q  <= last_d;
    pend_q  <= pend_d;
    prev_q  <= prev_d;
    ohops_q <= ohops_d;
    orate_q <= orate_d;
    edge_q  <= e_ra;
    racc_q  <= racc_d;
    rst_q   <= rst_d;
    ract_q  <= ract_d;
    rload_q <= rload_d;
    if (state_q == pbr_pkg::S_RESP && (!ovld_q || !out_stall_i)) begin
      oacc_q  <= racc_q;
      ost_q   <= rst_q;
      oact_q  <= ract_q;
      oload_q <= rload_q;
      ocnt_q  <= held_q;
    end
  end

  assign out_valid_o       = ovld_q;
  assign out_accepted_o    = oacc_q;
  assign out_status_o      = ost_q;
  assign out_edge_active_o = oact_q;
  assign out_edge_load_o   = oload_q;
  assign out_flow_count_o  = ocnt_q;

endmodule

FILE: hdl/pbr_checker.sv
// Port-level checker for the bandwidth reservation block, with its bind statement.
module pbr_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic                        out_accepted_o,
  input logic [2:0]                  out_status_o,
  input logic                        out_edge_active_o,
  input logic [pbr_pkg::CNT_W-1:0]   out_flow_count_o,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [3:0]                  paddr,
  input logic [63:0]                 pwdata,
  input logic [63:0]                 prdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("Result beat dropped while stalled.");

  a_acc_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_accepted_o == (out_status_o == pbr_pkg::ST_OK)))
    else $error("Accepted flag disagrees with status.");

  a_act_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_edge_active_o |-> out_accepted_o)
    else $error("Active edge reported on a failed command.");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_flow_count_o <= pbr_pkg::CNT_W'(256))
    else $error("Flow count exceeds the table size.");

  a_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && !paddr[3] |=> prdata[47:0] == $past(pwdata[47:0])
      || paddr[3])
    else $error("Capacity readback does not match the last write.");

endmodule

bind path_bandwidth_reservation pbr_checker u_pbr_checker (.*);
